// ===== rtl/drrpg_pkg.sv =====
// Shared types and constants for the dual round-robin pulse generator.
`default_nettype none

package drrpg_pkg;

    // Pulse length counters are as wide as the length fields.
    localparam int C_LEN_WIDTH   = 24;
    localparam int C_COUNT_WIDTH = C_LEN_WIDTH;
    localparam int C_LED_WIDTH   = 16;

    localparam logic [C_LED_WIDTH-1:0] C_LED_RESET = C_LED_WIDTH'(480);

    typedef logic [C_COUNT_WIDTH-1:0] t_count;
    typedef logic [C_LED_WIDTH-1:0]   t_led_count;

    typedef struct packed {
        logic                   clock_rise;
        logic                   clock_mult_rise;
        logic                   pulse_in1_patched;
        logic                   pulse_in2_patched;
        logic                   ext_pulse1;
        logic                   ext_pulse2;
        logic                   out1_enable;
        logic                   out2_enable;
        logic [C_LEN_WIDTH-1:0] main_length;
        logic [C_LEN_WIDTH-1:0] divide_length;
    } t_in_item;

    typedef struct packed {
        logic out1_level;
        logic out2_level;
        logic led1_level;
        logic led2_level;
        logic advance_main;
        logic advance_divide;
    } t_out_item;

endpackage

`default_nettype wire

// ===== rtl/drrpg_if.sv =====
// Valid/ready channel interfaces for input words, result words and config writes.
`default_nettype none

interface drrpg_in_if import drrpg_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface drrpg_out_if import drrpg_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface drrpg_cfg_if import drrpg_pkg::*; ();
    logic       valid;
    logic       ready;
    t_led_count data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/dual_round_robin_pulse_generator.sv =====
// Top level: input register, channel update core, result register, LED length register.
//
//  Channel   Direction  Payload                               Accepted when
//  i_in      sink       one tick: clock edges, pulses, lengths valid & ready
//  o_out     source     levels and advance strobes            valid & ready
//  i_cfg     sink       LED pulse length (16 bits)            valid & ready
//
// Each word goes through the input register, then the result register. One word
// per cycle is sustained while results are taken, limited by one core update step.
// Reset (synchronous, active low) clears all channel state and sets the LED
// length to 480. A stalled result holds its register; the input register still
// takes one more word, then input ready drops until the result drains.
`default_nettype none

module dual_round_robin_pulse_generator import drrpg_pkg::*; (
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    drrpg_in_if.sink     i_in,
    drrpg_out_if.source  o_out,
    drrpg_cfg_if.sink    i_cfg
);

    logic       r_in_valid;
    t_in_item   r_in_item;
    logic       r_out_valid;
    t_out_item  r_out_item;
    t_led_count r_led_ticks;
    logic       step;
    t_out_item  result;

    assign step        = r_in_valid & (~r_out_valid | o_out.ready);
    assign i_in.ready  = ~r_in_valid | step;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.item  = r_out_item;

    drrpg_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_item      (r_in_item),
        .i_led_ticks (r_led_ticks),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_led_ticks <= C_LED_RESET;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid) begin
                r_led_ticks <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_item <= i_in.item;
        end
        if (step) begin
            r_out_item <= result;
        end
    end

    // Only one channel is served per word, so both strobes never show together.
    a_one_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_item.advance_main && r_out_item.advance_divide))
        else $error("both advance strobes in one result word");

    a_step_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("processed word produced no result");

    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !step) |=> (r_in_valid && $stable(r_in_item)))
        else $error("waiting input word lost or changed");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> (r_out_valid && $stable(r_out_item)))
        else $error("stalled result word overwritten");

endmodule

`default_nettype wire

// ===== rtl/drrpg_core.sv =====
// Channel state and one-tick update: pending triggers, service toggle, countdowns.
`default_nettype none

module drrpg_core import drrpg_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire t_in_item   i_item,
    input  wire t_led_count i_led_ticks,
    output t_out_item       o_result
);

    logic       r_serve_first, n_serve_first;
    logic       r_pend1, n_pend1;
    logic       r_pend2, n_pend2;
    t_count     r_out_cnt1, n_out_cnt1;
    t_count     r_out_cnt2, n_out_cnt2;
    t_led_count r_led_cnt1, n_led_cnt1;
    t_led_count r_led_cnt2, n_led_cnt2;
    logic [3:0] r_active, n_active;
    logic [3:0] r_level, n_level;

    logic       trig1, trig2;
    logic       fire1, fire2;
    logic       load1, load2;
    t_count     len1, len2;
    t_led_count led_len;

    // Counter with load, then one decrement on its service slot.
    // Bit 0 of the returned value is the new active flag, bit 1 the new level, the rest the count.
    function automatic logic [C_COUNT_WIDTH+1:0] step_out(
        input logic   serve, input logic load, input t_count load_val,
        input logic   load_lvl, input t_count cnt, input logic act, input logic lvl);
        t_count c;
        logic   a;
        logic   l;
        c = load ? load_val : cnt;
        a = act | load;
        l = load ? load_lvl : lvl;
        if (serve && a) begin
            c = c - t_count'(1);
            if (c == '0) begin
                a = 1'b0;
                l = 1'b0;
            end
        end
        return {c, l, a};
    endfunction

    function automatic logic [C_LED_WIDTH+1:0] step_led(
        input logic       serve, input logic load, input t_led_count load_val,
        input logic       load_lvl, input t_led_count cnt, input logic act, input logic lvl);
        t_led_count c;
        logic       a;
        logic       l;
        c = load ? load_val : cnt;
        a = act | load;
        l = load ? load_lvl : lvl;
        if (serve && a) begin
            c = c - t_led_count'(1);
            if (c == '0) begin
                a = 1'b0;
                l = 1'b0;
            end
        end
        return {c, l, a};
    endfunction

    always_comb begin
        trig1 = r_pend1 | (i_item.clock_rise & ~i_item.pulse_in1_patched) | i_item.ext_pulse1;
        trig2 = r_pend2 | (i_item.clock_mult_rise & ~i_item.pulse_in2_patched)
              | i_item.ext_pulse2;
        fire1 = r_serve_first & trig1;
        fire2 = ~r_serve_first & trig2;
        // Channel 1 loads only when enabled; channel 2 always reloads.
        load1 = fire1 & i_item.out1_enable;
        load2 = fire2;
        // A length of zero counts as one slot.
        len1    = (i_item.main_length == '0) ? t_count'(1) : t_count'(i_item.main_length);
        len2    = (i_item.divide_length == '0) ? t_count'(1) : t_count'(i_item.divide_length);
        led_len = (i_led_ticks == '0) ? t_led_count'(1) : i_led_ticks;

        n_serve_first = ~r_serve_first;
        n_pend1       = r_serve_first ? 1'b0 : trig1;
        n_pend2       = r_serve_first ? trig2 : 1'b0;

        {n_out_cnt1, n_level[0], n_active[0]} = step_out(r_serve_first, load1, len1, 1'b1,
            r_out_cnt1, r_active[0], r_level[0]);
        {n_led_cnt1, n_level[1], n_active[1]} = step_led(r_serve_first, load1, led_len, 1'b1,
            r_led_cnt1, r_active[1], r_level[1]);
        {n_out_cnt2, n_level[2], n_active[2]} = step_out(~r_serve_first, load2, len2,
            i_item.out2_enable, r_out_cnt2, r_active[2], r_level[2]);
        {n_led_cnt2, n_level[3], n_active[3]} = step_led(~r_serve_first, load2, led_len,
            i_item.out2_enable, r_led_cnt2, r_active[3], r_level[3]);

        o_result.out1_level     = n_level[0];
        o_result.led1_level     = n_level[1];
        o_result.out2_level     = n_level[2];
        o_result.led2_level     = n_level[3];
        o_result.advance_main   = fire1;
        o_result.advance_divide = fire2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_serve_first <= 1'b0;
            r_pend1       <= 1'b0;
            r_pend2       <= 1'b0;
            r_out_cnt1    <= '0;
            r_out_cnt2    <= '0;
            r_led_cnt1    <= '0;
            r_led_cnt2    <= '0;
            r_active      <= '0;
            r_level       <= '0;
        end else if (i_step) begin
            r_serve_first <= n_serve_first;
            r_pend1       <= n_pend1;
            r_pend2       <= n_pend2;
            r_out_cnt1    <= n_out_cnt1;
            r_out_cnt2    <= n_out_cnt2;
            r_led_cnt1    <= n_led_cnt1;
            r_led_cnt2    <= n_led_cnt2;
            r_active      <= n_active;
            r_level       <= n_level;
        end
    end

endmodule

`default_nettype wire

// ===== test/drrpg_pulse_checker.sv =====
// Checker that predicts and compares the pulse generator's result words.
`timescale 1ns / 100ps

module drrpg_pulse_checker import drrpg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    drrpg_in_if         i_in,
    drrpg_out_if        i_out,
    drrpg_cfg_if        i_cfg,
    output int          o_fail_count,
    output int          o_outstanding,
    output int          o_results,
    output int          o_main_advances,
    output int          o_divide_advances
);

    // Bit positions in the running and level flag sets.
    localparam int B_OUT1 = 0;
    localparam int B_LED1 = 1;
    localparam int B_OUT2 = 2;
    localparam int B_LED2 = 3;

    logic       serve_ch1;
    logic       trig_pending1;
    logic       trig_pending2;
    t_count     out_left1;
    t_count     out_left2;
    t_led_count led_left1;
    t_led_count led_left2;
    logic [3:0] running;
    logic [3:0] levels;
    t_led_count led_len;

    t_out_item expected_levels[$];
    int        mismatches;
    int        results;
    int        main_advances;
    int        divide_advances;

    // The counters are as wide as the length fields, so only zero needs fixing.
    function automatic t_count pulse_load(logic [C_LEN_WIDTH-1:0] len);
        return (len == '0) ? t_count'(1) : t_count'(len);
    endfunction

    function automatic t_led_count flash_load();
        return (led_len == '0) ? t_led_count'(1) : led_len;
    endfunction

    task automatic advance_tick(input t_in_item w);
        t_out_item r;
        r = '0;
        if ((w.clock_rise && !w.pulse_in1_patched) || w.ext_pulse1) begin
            trig_pending1 = 1'b1;
        end
        if ((w.clock_mult_rise && !w.pulse_in2_patched) || w.ext_pulse2) begin
            trig_pending2 = 1'b1;
        end
        if (serve_ch1) begin
            if (trig_pending1) begin
                // A disabled channel 1 still advances, but leaves its pulse alone.
                if (w.out1_enable) begin
                    levels[B_OUT1]  = 1'b1;
                    levels[B_LED1]  = 1'b1;
                    running[B_OUT1] = 1'b1;
                    running[B_LED1] = 1'b1;
                    out_left1 = pulse_load(w.main_length);
                    led_left1 = flash_load();
                end
                r.advance_main = 1'b1;
                trig_pending1  = 1'b0;
            end
            if (running[B_OUT1]) begin
                out_left1 = out_left1 - 1'b1;
                if (out_left1 == '0) begin
                    running[B_OUT1] = 1'b0;
                    levels[B_OUT1]  = 1'b0;
                end
            end
            if (running[B_LED1]) begin
                led_left1 = led_left1 - 1'b1;
                if (led_left1 == '0) begin
                    running[B_LED1] = 1'b0;
                    levels[B_LED1]  = 1'b0;
                end
            end
        end else begin
            if (trig_pending2) begin
                // Channel 2 always reloads; the enable only sets the levels.
                levels[B_OUT2]  = w.out2_enable;
                levels[B_LED2]  = w.out2_enable;
                running[B_OUT2] = 1'b1;
                running[B_LED2] = 1'b1;
                out_left2 = pulse_load(w.divide_length);
                led_left2 = flash_load();
                r.advance_divide = 1'b1;
                trig_pending2    = 1'b0;
            end
            if (running[B_OUT2]) begin
                out_left2 = out_left2 - 1'b1;
                if (out_left2 == '0) begin
                    running[B_OUT2] = 1'b0;
                    levels[B_OUT2]  = 1'b0;
                end
            end
            if (running[B_LED2]) begin
                led_left2 = led_left2 - 1'b1;
                if (led_left2 == '0) begin
                    running[B_LED2] = 1'b0;
                    levels[B_LED2]  = 1'b0;
                end
            end
        end
        serve_ch1 = !serve_ch1;
        r.out1_level = levels[B_OUT1];
        r.out2_level = levels[B_OUT2];
        r.led1_level = levels[B_LED1];
        r.led2_level = levels[B_LED2];
        expected_levels.push_back(r);
    endtask

    task automatic check_field(input string field, input logic want, input logic got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %b, got %b", $time, field, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (expected_levels.size() == 0) begin
            $display("%0t: result word with nothing expected, expected none, got %b",
                     $time, got);
            mismatches++;
        end else begin
            want = expected_levels.pop_front();
            check_field("out1_level", want.out1_level, got.out1_level);
            check_field("out2_level", want.out2_level, got.out2_level);
            check_field("led1_level", want.led1_level, got.led1_level);
            check_field("led2_level", want.led2_level, got.led2_level);
            check_field("advance_main", want.advance_main, got.advance_main);
            check_field("advance_divide", want.advance_divide, got.advance_divide);
        end
        results++;
        if (got.advance_main === 1'b1) begin
            main_advances++;
        end
        if (got.advance_divide === 1'b1) begin
            divide_advances++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            serve_ch1     = 1'b0;
            trig_pending1 = 1'b0;
            trig_pending2 = 1'b0;
            out_left1     = '0;
            out_left2     = '0;
            led_left1     = '0;
            led_left2     = '0;
            running       = '0;
            levels        = '0;
            led_len       = C_LED_RESET;
            expected_levels.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                led_len = i_cfg.data;
            end
            // Predict before comparing so that any latency is handled.
            if (i_in.valid && i_in.ready) begin
                advance_tick(i_in.item);
            end
            if (i_out.valid && i_out.ready) begin
                check_result(i_out.item);
            end
        end
        o_fail_count      <= mismatches;
        o_outstanding     <= expected_levels.size();
        o_results         <= results;
        o_main_advances   <= main_advances;
        o_divide_advances <= divide_advances;
    end

endmodule

// ===== test/dual_round_robin_pulse_generator_tb.sv =====
// Stimulus and verdict for the dual round-robin pulse generator.
`timescale 1ns / 100ps

module dual_round_robin_pulse_generator_tb;
    import drrpg_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int NUM_PHASES  = 7;

    logic clk = 1'b0;
    logic rst_n;
    logic rx_ready = 1'b0;
    int   cycle_count = 0;

    int fail_count;
    int outstanding;
    int results;
    int main_advances;
    int divide_advances;

    int words_sent = 0;
    int burst_left = 0;
    int settings_used = 1;

    drrpg_in_if  in_ch();
    drrpg_out_if out_ch();
    drrpg_cfg_if cfg_ch();

    assign out_ch.ready = rx_ready;

    dual_round_robin_pulse_generator u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    drrpg_pulse_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in              (in_ch),
        .i_out             (out_ch),
        .i_cfg             (cfg_ch),
        .o_fail_count      (fail_count),
        .o_outstanding     (outstanding),
        .o_results         (results),
        .o_main_advances   (main_advances),
        .o_divide_advances (divide_advances)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // The receiver stalls on the clear bits of a 16-bit mask, redrawn when the 6-bit step wraps.
    logic [15:0] stall_mask = 16'hFFFF;
    logic [5:0]  stall_step = '0;

    always @(posedge clk) begin
        if (stall_step == '0) begin
            case ($urandom_range(0, 3))
                0: begin
                    stall_mask = 16'hFFFF;
                end
                1: begin
                    stall_mask = 16'($urandom()) | 16'h0001;
                end
                2: begin
                    stall_mask = 16'h5555;
                end
                default: begin
                    stall_mask = 16'hFFF0;
                end
            endcase
        end
        rx_ready <= stall_mask[stall_step[3:0]];
        stall_step = stall_step + 1'b1;
    end

    function automatic t_in_item make_word(
        input logic cr, input logic mr, input logic p1, input logic p2,
        input logic x1, input logic x2, input logic en1, input logic en2,
        input logic [C_LEN_WIDTH-1:0] ml, input logic [C_LEN_WIDTH-1:0] dl);
        t_in_item w;
        w.clock_rise        = cr;
        w.clock_mult_rise   = mr;
        w.pulse_in1_patched = p1;
        w.pulse_in2_patched = p2;
        w.ext_pulse1        = x1;
        w.ext_pulse2        = x2;
        w.out1_enable       = en1;
        w.out2_enable       = en2;
        w.main_length       = ml;
        w.divide_length     = dl;
        return w;
    endfunction

    // Mostly short pulses, so that pulse ends show up often.
    function automatic logic [C_LEN_WIDTH-1:0] random_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            return '0;
        end else if (pick < 70) begin
            return C_LEN_WIDTH'($urandom_range(1, 6));
        end else if (pick < 90) begin
            return C_LEN_WIDTH'($urandom_range(7, 40));
        end else if (pick < 96) begin
            return C_LEN_WIDTH'($urandom());
        end
        return '1;
    endfunction

    function automatic t_in_item random_word();
        return make_word($urandom_range(0, 99) < 35, $urandom_range(0, 99) < 35,
                         $urandom_range(0, 99) < 30, $urandom_range(0, 99) < 30,
                         $urandom_range(0, 99) < 20, $urandom_range(0, 99) < 20,
                         $urandom_range(0, 99) < 75, $urandom_range(0, 99) < 75,
                         random_length(), random_length());
    endfunction

    task automatic send_word(input t_in_item w);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        in_ch.item  <= w;
        in_ch.valid <= 1'b1;
        do @(posedge clk); while (!in_ch.ready);
        words_sent++;
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic write_led_len(input t_led_count v);
        cfg_ch.data  <= v;
        cfg_ch.valid <= 1'b1;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    initial begin
        t_in_item   directed_words[$];
        t_led_count phase_led[NUM_PHASES];
        int         phase_words[NUM_PHASES];
        t_led_count led_v;

        rst_n        <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.item   <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words run with the LED length left at its reset value.
        directed_words.push_back(make_word(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                           24'd0, 24'd0));
        directed_words.push_back(make_word(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1,
                                           24'd0, 24'd0));
        directed_words.push_back(make_word(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1,
                                           24'd0, 24'd0));
        directed_words.push_back(make_word(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1,
                                           24'd3, 24'd3));
        directed_words.push_back(make_word(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1,
                                           24'd3, 24'd3));
        directed_words.push_back(make_word(1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
                                           '1, '1));
        directed_words.push_back(make_word(1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1,
                                           24'd0, 24'd0));
        directed_words.push_back(make_word(1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0,
                                           24'd5, 24'd5));
        directed_words.push_back(make_word(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                           24'd5, 24'd5));
        directed_words.push_back(make_word(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1,
                                           24'd2, 24'd2));
        directed_words.push_back(make_word(1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1,
                                           24'd2, 24'd2));
        directed_words.push_back(make_word(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1,
                                           24'd4, 24'd4));
        directed_words.push_back(make_word(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1,
                                           24'd4, 24'd4));
        directed_words.push_back(make_word(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1,
                                           24'd4, 24'd4));
        directed_words.push_back(make_word(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1,
                                           24'd6, 24'd6));
        directed_words.push_back(make_word(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1,
                                           24'd6, 24'd6));
        directed_words.push_back(make_word(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1,
                                           24'd1, 24'd1));
        directed_words.push_back(make_word(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1,
                                           24'd1, 24'd1));
        directed_words.push_back(make_word(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0,
                                           24'h555555, 24'hAAAAAA));
        directed_words.push_back(make_word(1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0,
                                           24'hAAAAAA, 24'h555555));
        directed_words.push_back(make_word(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                                           24'h555555, 24'hAAAAAA));
        directed_words.push_back(make_word(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                           24'd0, 24'd0));
        foreach (directed_words[k]) begin
            send_word(directed_words[k]);
        end

        // LED length settings: shortest, zero, longest, three random, then a short one.
        phase_led   = '{16'd1, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd3};
        phase_words = '{250, 200, 200, 200, 200, 200, 180};
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            led_v = (p >= 3 && p <= 5) ? t_led_count'($urandom_range(2, 40)) : phase_led[p];
            write_led_len(led_v);
            for (int n = 0; n < phase_words[p]; n++) begin
                send_word(random_word());
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);

        $display("Run sent %0d input words across %0d LED length settings, %0d results checked.",
                 words_sent, settings_used, results);
        $display("Advance strobes seen: %0d main, %0d divide.", main_advances, divide_advances);
        if (fail_count == 0 && outstanding == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
